FILE: hdl/dnstxt_pkg.sv
package dnstxt_pkg;

  // Key table geometry.
  localparam int KEY_COUNT   = 8;
  localparam int MAX_KEY_LEN = 8;
  localparam int MASK_W      = KEY_COUNT + 1;

  typedef logic [7:0] char_t;
  typedef logic [3:0] key_pos_t;
  typedef logic [2:0] target_t;
  typedef logic [MASK_W-1:0] key_mask_t;

  // All candidates live, the spare top bit included.
  localparam key_mask_t MASK_ALL   = '1;
  localparam key_mask_t MASK_SPARE = key_mask_t'(1) << KEY_COUNT;

  // Target codes.
  localparam target_t TGT_OS       = 3'd0;
  localparam target_t TGT_HW       = 3'd1;
  localparam target_t TGT_MODEL    = 3'd2;
  localparam target_t TGT_MFG      = 3'd3;
  localparam target_t TGT_URL      = 3'd4;
  localparam target_t TGT_NO_MATCH = 3'd7;

  localparam char_t CHAR_EQUALS = 8'h3D;
  localparam char_t CHAR_UPPER_A = 8'h41;
  localparam char_t CHAR_UPPER_Z = 8'h5A;
  localparam char_t CASE_OFFSET  = 8'h20;

  // Known keys, lower case, padded with zero bytes.
  localparam char_t KEY_TEXT [KEY_COUNT][MAX_KEY_LEN] = '{
    '{8'h6F, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // os
    '{8'h68, 8'h77, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // hw
    '{8'h6D, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // md
    '{8'h6D, 8'h64, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // mdl
    '{8'h75, 8'h73, 8'h62, 8'h5F, 8'h6D, 8'h64, 8'h6C, 8'h00},  // usb_mdl
    '{8'h6D, 8'h66, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // mfg
    '{8'h75, 8'h73, 8'h62, 8'h5F, 8'h6D, 8'h66, 8'h67, 8'h00},  // usb_mfg
    '{8'h61, 8'h64, 8'h6D, 8'h69, 8'h6E, 8'h75, 8'h72, 8'h6C}   // adminurl
  };

  localparam key_pos_t KEY_LEN [KEY_COUNT] = '{
    4'd2, 4'd2, 4'd2, 4'd3, 4'd7, 4'd3, 4'd7, 4'd8
  };

  localparam target_t KEY_TARGET [KEY_COUNT] = '{
    TGT_OS, TGT_HW, TGT_MODEL, TGT_MODEL, TGT_MODEL, TGT_MFG, TGT_MFG, TGT_URL
  };

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_VALUE     = 2'd1,
    KIND_EMPTY     = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_e;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_KEY  = 4'b0010,
    PH_VAL  = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_e;

  // Outcome of one key byte, from the key matcher.
  typedef struct packed {
    key_mask_t mask;
    key_pos_t  pos;
    target_t   target;
  } key_step_t;

  // One result item.
  typedef struct packed {
    kind_e      kind;
    target_t    target;
    logic [7:0] value_byte;
    logic       value_last;
    logic       record_done;
  } result_t;

endpackage

FILE: hdl/dnstxt_in_if.sv
interface dnstxt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_last;

  modport source (output valid, output data_byte, output record_last, input ready);
  modport sink   (input valid, input data_byte, input record_last, output ready);
endinterface

FILE: hdl/dnstxt_out_if.sv
interface dnstxt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] target;
  logic [7:0] value_byte;
  logic       value_last;
  logic       record_done;

  modport source (output valid, output kind, output target, output value_byte,
                  output value_last, output record_done, input ready);
  modport sink   (input valid, input kind, input target, input value_byte,
                  input value_last, input record_done, output ready);
endinterface

FILE: hdl/dnstxt_key_match.sv
module dnstxt_key_match (
  input  logic [7:0]           data_byte_i,
  input  dnstxt_pkg::key_pos_t  key_pos_i,
  input  dnstxt_pkg::key_mask_t key_mask_i,
  output dnstxt_pkg::key_step_t step_o
);
  import dnstxt_pkg::*;

  char_t lower_byte;

  // Fold ASCII upper case onto lower case.
  always_comb begin
    if (data_byte_i >= CHAR_UPPER_A && data_byte_i <= CHAR_UPPER_Z) begin
      lower_byte = data_byte_i + CASE_OFFSET;
    end else begin
      lower_byte = data_byte_i;
    end
  end

  // Narrow the candidate set by the current key byte, and find which
  // surviving key has exactly the length seen so far (last one wins).
  always_comb begin
    step_o.mask   = key_mask_i;
    step_o.pos    = key_pos_i;
    step_o.target = TGT_NO_MATCH;
    if (key_pos_i < key_pos_t'(MAX_KEY_LEN)) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        if (key_pos_i >= KEY_LEN[i] ||
            KEY_TEXT[i][key_pos_i[$clog2(MAX_KEY_LEN)-1:0]] != lower_byte) begin
          step_o.mask[i] = 1'b0;
        end
      end
      step_o.pos = key_pos_i + key_pos_t'(1);
    end else begin
      step_o.mask = key_mask_i & MASK_SPARE;
    end
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (key_mask_i[i] && KEY_LEN[i] == key_pos_i) begin
        step_o.target = KEY_TARGET[i];
      end
    end
  end

endmodule

FILE: hdl/dnssd_txt_key_value_parser_core.sv
// TXT record key/value parser.
//
// Input channel in_i carries one byte of TXT record data per request, with
// record_last set on the final byte of the record. Output channel out_o gives
// exactly one result per input request: kind none, a value byte tagged with
// its target field, an empty-value marker for a matched key, or a malformed
// record report. record_done is set on the result of the record's last byte.
// Both channels use a valid/ready handshake.
//
// Throughput is one byte per cycle while the skid register is empty; the key
// match and state update are one compare per key table entry, done in the
// acceptance cycle. An output register plus one skid register decouple the
// two sides, so a request is accepted while a result waits; when the
// receiver stalls with both registers full, in_i.ready drops until the
// output register drains.
//
// Reset (rst_ni low, asynchronous) empties both result registers and returns
// the parser to expecting a length byte with all keys as candidates.
module dnssd_txt_key_value_parser_core (
  input  logic clk_i,
  input  logic rst_ni,
  dnstxt_in_if.sink    in_i,
  dnstxt_out_if.source out_o
);
  import dnstxt_pkg::*;

  phase_e    phase_q, phase_d;
  logic [7:0] remaining_q, remaining_d;
  key_pos_t  key_pos_q, key_pos_d;
  key_mask_t key_mask_q, key_mask_d;
  target_t   matched_q, matched_d;

  result_t   res;
  result_t   out_q, skid_q;
  logic      out_valid_q, skid_valid_q;
  logic      accept;
  logic      out_take;
  logic [7:0] rem_dec;
  key_step_t key_step;

  assign in_i.ready = ~skid_valid_q;
  assign accept     = in_i.valid & in_i.ready;
  assign out_take   = out_valid_q & out_o.ready;
  assign rem_dec    = remaining_q - 8'd1;

  dnstxt_key_match u_key_match (
    .data_byte_i (in_i.data_byte),
    .key_pos_i   (key_pos_q),
    .key_mask_i  (key_mask_q),
    .step_o      (key_step)
  );

  // Next state and result for the byte on the input channel.
  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    key_pos_d   = key_pos_q;
    key_mask_d  = key_mask_q;
    matched_d   = matched_q;
    res         = '{kind: KIND_NONE, target: TGT_OS, value_byte: 8'd0,
                    value_last: 1'b0, record_done: in_i.record_last};

    unique case (phase_q)
      PH_LEN: begin
        if (in_i.data_byte == 8'd0) begin
          // Zero-length pair is skipped.
          phase_d = PH_LEN;
        end else if (in_i.record_last) begin
          res.kind = KIND_MALFORMED;
          phase_d  = PH_LEN;
        end else begin
          phase_d     = PH_KEY;
          remaining_d = in_i.data_byte;
          key_pos_d   = '0;
          key_mask_d  = MASK_ALL;
        end
      end
      PH_KEY: begin
        remaining_d = rem_dec;
        if (in_i.data_byte == CHAR_EQUALS) begin
          matched_d = key_step.target;
          if (rem_dec == 8'd0) begin
            if (key_step.target != TGT_NO_MATCH) begin
              res.kind       = KIND_EMPTY;
              res.target     = key_step.target;
              res.value_last = 1'b1;
            end
            phase_d = PH_LEN;
          end else if (in_i.record_last) begin
            res.kind = KIND_MALFORMED;
            phase_d  = PH_LEN;
          end else begin
            phase_d = PH_VAL;
          end
        end else begin
          key_mask_d = key_step.mask;
          key_pos_d  = key_step.pos;
          // Pair ends or record ends without an equals sign.
          if (rem_dec == 8'd0 || in_i.record_last) begin
            res.kind = KIND_MALFORMED;
            phase_d  = in_i.record_last ? PH_LEN : PH_SKIP;
          end
        end
      end
      PH_VAL: begin
        remaining_d = rem_dec;
        if (in_i.record_last && rem_dec != 8'd0) begin
          res.kind = KIND_MALFORMED;
          phase_d  = PH_LEN;
        end else begin
          if (matched_q != TGT_NO_MATCH) begin
            res.kind       = KIND_VALUE;
            res.target     = matched_q;
            res.value_byte = in_i.data_byte;
            res.value_last = (rem_dec == 8'd0);
          end
          if (rem_dec == 8'd0) begin
            phase_d = PH_LEN;
          end
        end
      end
      PH_SKIP: begin
        if (in_i.record_last) begin
          phase_d = PH_LEN;
        end
      end
      default: begin
        phase_d = PH_LEN;
      end
    endcase

    // Returning to the length phase clears the pair context.
    if (phase_d == PH_LEN) begin
      remaining_d = '0;
      key_pos_d   = '0;
      key_mask_d  = MASK_ALL;
    end
  end

  // Parser state, updated on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN;
      remaining_q <= '0;
      key_pos_q   <= '0;
      key_mask_q  <= MASK_ALL;
      matched_q   <= TGT_OS;
    end else if (accept) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      key_pos_q   <= key_pos_d;
      key_mask_q  <= key_mask_d;
      matched_q   <= matched_d;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result payloads follow the same steering.
  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.target      = out_q.target;
  assign out_o.value_byte  = out_q.value_byte;
  assign out_o.value_last  = out_q.value_last;
  assign out_o.record_done = out_q.record_done;

endmodule

FILE: verif/tb_top.sv
module tb_top;
  import dnstxt_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_REPORTS  = 10;
  localparam int WAIT_MAX     = 13;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  dnstxt_in_if  txt_in ();
  dnstxt_out_if txt_out ();

  dnssd_txt_key_value_parser_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (txt_in),
    .out_o  (txt_out)
  );

  // Results predicted for accepted bytes, oldest first.
  result_t field_results_q[$];

  // Bytes of the record being built for sending.
  char_t record_q[$];

  int bad_results  = 0;
  int bytes_sent   = 0;
  int cycle_count  = 0;
  int src_wait_max  = WAIT_MAX;
  int sink_wait_max = WAIT_MAX;

  // Parser state as the testbench sees it, starting from its reset values.
  phase_e    cur_phase  = PH_LEN;
  char_t     bytes_left = '0;
  key_pos_t  key_pos    = '0;
  key_mask_t key_cand   = MASK_ALL;
  target_t   cur_target = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Back to waiting for a length byte with every key still a candidate.
  function automatic void restart_record();
    cur_phase  = PH_LEN;
    bytes_left = '0;
    key_pos    = '0;
    key_cand   = MASK_ALL;
  endfunction

  // Work out the result of one record byte and advance the parser state.
  function automatic result_t parse_txt_byte(input char_t b, input logic last);
    result_t r;
    char_t   c;
    r = '0;
    r.kind = KIND_NONE;
    r.record_done = last;
    case (cur_phase)
      PH_LEN: begin
        if (b == 8'd0) begin
          if (last) restart_record();
        end else if (last) begin
          r.kind = KIND_MALFORMED;
          restart_record();
        end else begin
          cur_phase  = PH_KEY;
          bytes_left = b;
          key_pos    = '0;
          key_cand   = MASK_ALL;
        end
      end
      PH_KEY: begin
        bytes_left = bytes_left - 8'd1;
        if (b == CHAR_EQUALS) begin
          // The key ends here; a surviving candidate of exactly this length wins.
          cur_target = TGT_NO_MATCH;
          for (int i = 0; i < KEY_COUNT; i++) begin
            if (key_cand[i] && KEY_LEN[i] == key_pos) cur_target = KEY_TARGET[i];
          end
          if (bytes_left == 8'd0) begin
            if (cur_target != TGT_NO_MATCH) begin
              r.kind       = KIND_EMPTY;
              r.target     = cur_target;
              r.value_last = 1'b1;
            end
            restart_record();
          end else if (last) begin
            r.kind = KIND_MALFORMED;
            restart_record();
          end else begin
            cur_phase = PH_VAL;
          end
        end else begin
          c = b;
          if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) c = c + CASE_OFFSET;
          if (key_pos < MAX_KEY_LEN) begin
            for (int i = 0; i < KEY_COUNT; i++) begin
              if (key_pos >= KEY_LEN[i] || KEY_TEXT[i][key_pos[2:0]] != c) key_cand[i] = 1'b0;
            end
            key_pos = key_pos + 4'd1;
          end else begin
            // Too long for any known key.
            key_cand = key_cand & MASK_SPARE;
          end
          // A pair that ends, or a record that stops, before its '='.
          if (bytes_left == 8'd0 || last) begin
            r.kind = KIND_MALFORMED;
            if (last) restart_record();
            else cur_phase = PH_SKIP;
          end
        end
      end
      PH_VAL: begin
        bytes_left = bytes_left - 8'd1;
        if (last && bytes_left != 8'd0) begin
          r.kind = KIND_MALFORMED;
          restart_record();
        end else begin
          if (cur_target != TGT_NO_MATCH) begin
            r.kind       = KIND_VALUE;
            r.target     = cur_target;
            r.value_byte = b;
            r.value_last = (bytes_left == 8'd0);
          end
          if (bytes_left == 8'd0) restart_record();
        end
      end
      default: begin
        if (last) restart_record();
      end
    endcase
    return r;
  endfunction

  // Offer one byte after a random gap and predict its result once accepted.
  task automatic send_byte(input char_t b, input logic last);
    int gap;
    gap = $urandom_range(0, src_wait_max);
    if (gap > 0) begin
      txt_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    txt_in.valid       <= 1'b1;
    txt_in.data_byte   <= b;
    txt_in.record_last <= last;
    @(posedge clk);
    while (txt_in.ready !== 1'b1) @(posedge clk);
    field_results_q.push_back(parse_txt_byte(b, last));
    bytes_sent++;
  endtask

  // Send the record held in record_q, marking its final byte.
  task automatic send_record();
    int n;
    n = record_q.size();
    for (int i = 0; i < n; i++) send_byte(record_q[i], i == n - 1);
  endtask

  // Stop offering bytes until every predicted result has arrived.
  task automatic drain_results();
    txt_in.valid <= 1'b0;
    @(posedge clk);
    while (field_results_q.size() != 0) @(posedge clk);
  endtask

  function automatic char_t mixed_case(input char_t c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) return c - CASE_OFFSET;
    return c;
  endfunction

  // Any byte but the separator.
  function automatic char_t key_char();
    char_t c;
    c = char_t'($urandom_range(0, 255));
    if (c == CHAR_EQUALS) c = CHAR_UPPER_A;
    return c;
  endfunction

  // Append one length-prefixed pair to record_q. Below broken_pct the pair is
  // zero-length, lacks its '=', or is random bytes.
  task automatic add_pair(input int broken_pct);
    char_t pair_q[$];
    int    shape;
    int    known;
    int    n;
    known = $urandom_range(0, KEY_COUNT - 1);
    if ($urandom_range(0, 99) >= broken_pct) begin
      shape = $urandom_range(0, 10);
      if (shape < KEY_COUNT) begin
        for (int i = 0; i < KEY_LEN[shape]; i++) pair_q.push_back(mixed_case(KEY_TEXT[shape][i]));
      end else if (shape == 8) begin
        // Leading part of a known key, up to the whole key.
        n = $urandom_range(1, KEY_LEN[known]);
        for (int i = 0; i < n; i++) pair_q.push_back(mixed_case(KEY_TEXT[known][i]));
      end else if (shape == 9) begin
        // Known key followed by extra letters.
        for (int i = 0; i < KEY_LEN[known]; i++) pair_q.push_back(mixed_case(KEY_TEXT[known][i]));
        repeat ($urandom_range(1, 3))
          pair_q.push_back(mixed_case(char_t'(8'h61 + $urandom_range(0, 25))));
      end else begin
        repeat ($urandom_range(0, 12)) pair_q.push_back(key_char());
      end
      pair_q.push_back(CHAR_EQUALS);
      n = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 240) : $urandom_range(0, 8);
      repeat (n) pair_q.push_back(char_t'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 2))
        0: ;
        1: repeat ($urandom_range(1, 10)) pair_q.push_back(key_char());
        default: repeat ($urandom_range(1, 12)) pair_q.push_back(char_t'($urandom_range(0, 255)));
      endcase
    end
    record_q.push_back(char_t'(pair_q.size()));
    foreach (pair_q[i]) record_q.push_back(pair_q[i]);
  endtask

  // Build and send a record of one to four pairs, now and then cut short.
  task automatic send_random_record(input int broken_pct, input int cut_pct);
    int keep;
    record_q.delete();
    repeat ($urandom_range(1, 4)) add_pair(broken_pct);
    if ($urandom_range(0, 99) < cut_pct) begin
      keep = $urandom_range(1, record_q.size());
      while (record_q.size() > keep) void'(record_q.pop_back());
    end
    // Vary the idling per record, with stretches where neither side waits.
    case ($urandom_range(0, 5))
      0: begin src_wait_max = 0;        sink_wait_max = 0;        end
      1: begin src_wait_max = 0;        sink_wait_max = WAIT_MAX; end
      2: begin src_wait_max = WAIT_MAX; sink_wait_max = 0;        end
      default: begin src_wait_max = WAIT_MAX; sink_wait_max = WAIT_MAX; end
    endcase
    send_record();
  endtask

  // Short records for each special case, with extreme byte values.
  task automatic test_corner_records();
    // "Os=" empty value, a zero-length pair, then "hW=" with bytes 00 and FF.
    record_q = '{8'h03, 8'h4F, 8'h73, 8'h3D, 8'h00,
                 8'h05, 8'h68, 8'h57, 8'h3D, 8'h00, 8'hFF};
    send_record();
    // "md" with no '=', rest of the record ignored.
    record_q = '{8'h02, 8'h6D, 8'h64, 8'h00};
    send_record();
    // Record ending inside the value of "os=".
    record_q = '{8'h05, 8'h6F, 8'h73, 8'h3D, 8'h61};
    send_record();
    // Record ending on a length byte of 255.
    record_q = '{8'hFF};
    send_record();
    // Record holding only a zero-length pair.
    record_q = '{8'h00};
    send_record();
    // Empty key whose '=' is cut short by the end of the record.
    record_q = '{8'h03, 8'h3D};
    send_record();
    drain_results();
  endtask

  // Mostly well-formed records with random keys and values.
  task automatic test_well_formed_records();
    int records;
    records = 0;
    while (bytes_sent < 1150) begin
      send_random_record(10, 5);
      records++;
      if (records % 25 == 0) drain_results();
    end
    drain_results();
  endtask

  // Records heavy with missing separators, noise and early ends.
  task automatic test_broken_records();
    while (bytes_sent < 1670) send_random_record(60, 40);
  endtask

  // Receiver: random stalls, then check each result against the prediction.
  initial begin
    int      wait_cycles;
    result_t want;
    txt_out.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      wait_cycles = $urandom_range(0, sink_wait_max);
      if (wait_cycles > 0) begin
        txt_out.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      txt_out.ready <= 1'b1;
      @(posedge clk);
      while (txt_out.valid !== 1'b1) @(posedge clk);
      if (field_results_q.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("unexpected result: kind %0d target %0d byte %02h last %0b done %0b",
                   txt_out.kind, txt_out.target, txt_out.value_byte,
                   txt_out.value_last, txt_out.record_done);
      end else begin
        want = field_results_q.pop_front();
        if (txt_out.kind !== want.kind || txt_out.target !== want.target ||
            txt_out.value_byte !== want.value_byte ||
            txt_out.value_last !== want.value_last ||
            txt_out.record_done !== want.record_done) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("mismatch: expected kind %0d target %0d byte %02h last %0b done %0b, %s",
                     want.kind, want.target, want.value_byte, want.value_last,
                     want.record_done,
                     $sformatf("got kind %0d target %0d byte %02h last %0b done %0b",
                               txt_out.kind, txt_out.target, txt_out.value_byte,
                               txt_out.value_last, txt_out.record_done));
        end
      end
    end
  end

  // Reset, run the tests in turn, then wait for the last results.
  initial begin
    rst_n              = 1'b0;
    txt_in.valid       = 1'b0;
    txt_in.data_byte   = '0;
    txt_in.record_last = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_records();
    test_well_formed_records();
    test_broken_records();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
